### rtl/srrs_pkg.sv
package srrs_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 16;
  localparam int VAL_W  = 16;
  localparam int ENT_W  = KEY_W + VAL_W;

  typedef logic [1:0] op_t;
  localparam op_t OP_PUSH    = 2'd0;
  localparam op_t OP_ADVANCE = 2'd1;
  localparam op_t OP_SELECT  = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_EMPTY     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_CUR_RD,
    S_OUT
  } state_t;

endpackage

### rtl/srrs_in_if.sv
interface srrs_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic signed [15:0]  request_key;
  logic [15:0]         request_value;

  modport source (output valid, op, request_key, request_value, input ready);
  modport sink   (input valid, op, request_key, request_value, output ready);
endinterface

### rtl/srrs_out_if.sv
interface srrs_out_if;
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic signed [15:0]  entry_key;
  logic [15:0]         entry_value;
  logic                current_valid;
  logic signed [15:0]  current_key;
  logic [15:0]         current_value;
  logic [4:0]          entry_count;

  modport source (output valid, status, entry_key, entry_value, current_valid,
                  current_key, current_value, entry_count, input ready);
  modport sink   (input valid, status, entry_key, entry_value, current_valid,
                  current_key, current_value, entry_count, output ready);
endinterface

### rtl/sorted_round_robin_scheduler_unit.sv
// advance, unused codes and empty select go straight to reading the current entry;
// push and select scan from entry 0 while keys are below the request, stopping at the end,
// and an insert shifts the later entries up one place before writing the new entry
// throughput: one transaction at a time, the next accepted in the cycle the result is offered;
// table ram, registered read: a search step reads then compares, a shift step reads then writes
// reset: synchronous active-low rst_n empties the table and clears the pointer; ram not cleared
module sorted_round_robin_scheduler_unit (
  input  logic clk,
  input  logic rst_n,
  srrs_in_if.sink    in_if,
  srrs_out_if.source out_if
);
  import srrs_pkg::*;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic                pvalid_r, pvalid_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    sh_r, sh_nxt;
  logic                found_r, found_nxt;
  status_t             status_r, status_nxt;
  logic [KEY_W-1:0]    ek_r, ek_nxt;
  logic [VAL_W-1:0]    ev_r, ev_nxt;

  logic                ov_r, ov_nxt;
  status_t             o_status_r, o_status_nxt;
  logic [KEY_W-1:0]    o_ek_r, o_ek_nxt;
  logic [VAL_W-1:0]    o_ev_r, o_ev_nxt;
  logic                o_cv_r, o_cv_nxt;
  logic [KEY_W-1:0]    o_ck_r, o_ck_nxt;
  logic [VAL_W-1:0]    o_cval_r, o_cval_nxt;
  logic [CNT_W-1:0]    o_cnt_r, o_cnt_nxt;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENT_W-1:0]    ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [VAL_W-1:0]    rd_val;
  logic                accept, out_load, cur_ok;
  logic [CNT_W-1:0]    ptr_inc;

  srrs_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[ENT_W-1:VAL_W];
  assign rd_val   = ram_rdata[VAL_W-1:0];
  assign accept   = in_if.valid && in_if.ready;
  assign out_load = (state_r == S_OUT) && (!ov_r || out_if.ready);
  assign cur_ok   = pvalid_r && ({1'b0, ptr_r} < count_r);
  assign ptr_inc  = {1'b0, ptr_r} + CNT_W'(1);

  assign in_if.ready          = (state_r == S_IDLE);
  assign out_if.valid         = ov_r;
  assign out_if.status        = o_status_r;
  assign out_if.entry_key     = o_ek_r;
  assign out_if.entry_value   = o_ev_r;
  assign out_if.current_valid = o_cv_r;
  assign out_if.current_key   = o_ck_r;
  assign out_if.current_value = o_cval_r;
  assign out_if.entry_count   = o_cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_if.op == OP_PUSH) ||
              ((in_if.op == OP_SELECT) && (count_r != '0))) begin
            state_nxt = S_SRCH_RD;
          end else begin
            state_nxt = S_CUR_RD;
          end
        end
      end
      S_SRCH_RD:  state_nxt = (idx_r == count_r) ? S_DECIDE : S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = ($signed(rd_key) < $signed(key_r)) ? S_SRCH_RD : S_DECIDE;
      S_DECIDE: begin
        if ((op_r == OP_PUSH) && !found_r && (count_r != CNT_W'(DEPTH))) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_CUR_RD;
        end
      end
      S_SHIFT_RD: state_nxt = (sh_r == idx_r) ? S_INSERT : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_INSERT:   state_nxt = S_CUR_RD;
      S_CUR_RD:   state_nxt = S_OUT;
      S_OUT:      state_nxt = out_load ? S_IDLE : S_OUT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    pvalid_nxt = pvalid_r;
    idx_nxt    = idx_r;
    sh_nxt     = sh_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    ek_nxt     = ek_r;
    ev_nxt     = ev_r;
    ram_we     = 1'b0;
    ram_waddr  = sh_r[ADDR_W-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_if.op;
          key_nxt    = in_if.request_key;
          val_nxt    = in_if.request_value;
          idx_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          ek_nxt     = '0;
          ev_nxt     = '0;
          if (((in_if.op == OP_ADVANCE) || (in_if.op == OP_SELECT)) && (count_r == '0)) begin
            status_nxt = ST_EMPTY;
          end else if (in_if.op == OP_ADVANCE) begin
            pvalid_nxt = 1'b1;
            if (!pvalid_r || (ptr_inc >= count_r)) begin
              ptr_nxt = '0;
            end else begin
              ptr_nxt = ptr_inc[ADDR_W-1:0];
            end
          end
        end
      end
      S_SRCH_RD: begin
        if (idx_r != count_r) begin
          ram_re = 1'b1;
        end
      end
      S_SRCH_CMP: begin
        if ($signed(rd_key) < $signed(key_r)) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else if (rd_key == key_r) begin
          found_nxt = 1'b1;
          ek_nxt    = rd_key;
          ev_nxt    = rd_val;
        end
      end
      S_DECIDE: begin
        sh_nxt = count_r;
        if (op_r == OP_SELECT) begin
          ek_nxt = '0;
          ev_nxt = '0;
          if (found_r) begin
            ptr_nxt    = idx_r[ADDR_W-1:0];
            pvalid_nxt = 1'b1;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end else if (found_r) begin
          status_nxt = ST_DUPLICATE;
        end else if (count_r == CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end
      end
      S_SHIFT_RD: begin
        if (sh_r != idx_r) begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(sh_r - CNT_W'(1));
        end
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
        sh_nxt = sh_r - CNT_W'(1);
      end
      S_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = {key_r, val_r};
        count_nxt = count_r + CNT_W'(1);
        ek_nxt    = key_r;
        ev_nxt    = val_r;
        if (pvalid_r && ({1'b0, ptr_r} >= idx_r)) begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      S_CUR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    ov_nxt       = ov_r && !out_if.ready;
    o_status_nxt = o_status_r;
    o_ek_nxt     = o_ek_r;
    o_ev_nxt     = o_ev_r;
    o_cv_nxt     = o_cv_r;
    o_ck_nxt     = o_ck_r;
    o_cval_nxt   = o_cval_r;
    o_cnt_nxt    = o_cnt_r;
    if (out_load) begin
      ov_nxt       = 1'b1;
      o_status_nxt = status_r;
      o_ek_nxt     = ek_r;
      o_ev_nxt     = ev_r;
      o_cv_nxt     = cur_ok;
      o_ck_nxt     = cur_ok ? rd_key : '0;
      o_cval_nxt   = cur_ok ? rd_val : '0;
      o_cnt_nxt    = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ptr_r    <= '0;
      pvalid_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      pvalid_r <= pvalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    sh_r       <= sh_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    ek_r       <= ek_nxt;
    ev_r       <= ev_nxt;
    o_status_r <= o_status_nxt;
    o_ek_r     <= o_ek_nxt;
    o_ev_r     <= o_ev_nxt;
    o_cv_r     <= o_cv_nxt;
    o_ck_r     <= o_ck_nxt;
    o_cval_r   <= o_cval_nxt;
    o_cnt_r    <= o_cnt_nxt;
  end

endmodule

### rtl/srrs_ram.sv
module srrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
